// ===== src/xcd_pkg.sv =====
// Package: shared constants and command/status types of the packet deframer.
`timescale 1ns / 1ps
package xcd_pkg;

  localparam int PayloadMax = 32;
  localparam int StoreDepth = PayloadMax + 1;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int LenW       = 6;
  localparam int CntW       = $clog2(StoreDepth + 1);
  localparam int ByteW      = 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 8;

  localparam logic [CfgIdxW-1:0] CfgExpLen    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartFlag = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEndFlag   = 2'd2;

  localparam logic [LenW-1:0]  ExpLenReset    = 6'd1;
  localparam logic [ByteW-1:0] StartFlagReset = 8'd0;
  localparam logic [ByteW-1:0] EndFlagReset   = 8'd0;

  typedef struct packed {
    logic take;
    logic emit_start;
    logic rd_en;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic end_good;
    logic out_free;
    logic at_last;
  } dp_status_t;

endpackage

// ===== src/xcd_if.sv =====
// Interfaces: receive byte channel and payload output channel.
`timescale 1ns / 1ps
interface xcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last;
  modport source (output valid, output payload_byte, output last, input ready);
  modport sink (input valid, input payload_byte, input last, output ready);
endinterface

// ===== src/xcd_ctrl.sv =====
// Controller: sequences byte intake and readout of a verified packet.
`timescale 1ns / 1ps
module xcd_ctrl
  import xcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0] state_q, state_d;

  assign rx_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.take = rx_valid_i;
        if (rx_valid_i && status_i.end_good) begin
          cmd_o.emit_start = 1'b1;
          state_d          = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StLoad;
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = status_i.at_last ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/xcd_dp.sv =====
// Datapath: config registers, frame tracking, packet store and output register.
`timescale 1ns / 1ps
module xcd_dp
  import xcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [ByteW-1:0]    rx_byte_i,
  input  logic                tx_ready_i,
  output logic                tx_valid_o,
  output logic [ByteW-1:0]    tx_byte_o,
  output logic                tx_last_o,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o
);

  logic [LenW-1:0]  exp_len_q;
  logic [ByteW-1:0] start_flag_q, end_flag_q;

  logic             header_q, header_d;
  logic [LenW-1:0]  acc_len_q, acc_len_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic             wr_en;

  logic [ByteW-1:0] mem [StoreDepth];
  logic [ByteW-1:0] rd_data_q;
  logic [AddrW-1:0] idx_q;
  logic [AddrW-1:0] last_idx_q;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  logic             is_start, is_end;
  logic [CntW-1:0]  fill_m1;

  assign is_start = (rx_byte_i == start_flag_q);
  assign is_end   = !is_start && (rx_byte_i == end_flag_q);
  assign fill_m1  = fill_q - CntW'(1);

  assign status_o.end_good = is_end
      && (fill_q >= CntW'(2)) && (fill_q <= CntW'(StoreDepth))
      && (fill_m1 == CntW'(acc_len_q)) && (fill_m1 == CntW'(exp_len_q))
      && (xor_q == ByteW'(acc_len_q));
  assign status_o.out_free = !out_valid_q || tx_ready_i;
  assign status_o.at_last  = (idx_q == last_idx_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q    <= ExpLenReset;
      start_flag_q <= StartFlagReset;
      end_flag_q   <= EndFlagReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExpLen:    exp_len_q    <= cfg_data_i[LenW-1:0];
        CfgStartFlag: start_flag_q <= cfg_data_i[ByteW-1:0];
        CfgEndFlag:   end_flag_q   <= cfg_data_i[ByteW-1:0];
        default:      ;
      endcase
    end
  end

  // frame tracking
  always_comb begin
    header_d  = header_q;
    acc_len_d = acc_len_q;
    fill_d    = fill_q;
    xor_d     = xor_q;
    wr_en     = 1'b0;
    if (cmd_i.take) begin
      priority if (is_start) begin
        header_d  = 1'b1;
        acc_len_d = '0;
        fill_d    = '0;
        xor_d     = '0;
      end else if (is_end) begin
        header_d  = 1'b0;
        acc_len_d = '0;
        fill_d    = '0;
        xor_d     = '0;
      end else if (header_q && (acc_len_q == '0)) begin
        if (rx_byte_i == ByteW'(exp_len_q)) begin
          acc_len_d = rx_byte_i[LenW-1:0];
        end else begin
          header_d = 1'b0;
          fill_d   = '0;
          xor_d    = '0;
        end
      end else if (header_q) begin
        if (fill_q < CntW'(StoreDepth)) begin
          wr_en  = 1'b1;
          fill_d = fill_q + CntW'(1);
          xor_d  = xor_q ^ rx_byte_i;
        end else begin
          header_d  = 1'b0;
          acc_len_d = '0;
          fill_d    = '0;
          xor_d     = '0;
        end
      end else begin
        // byte outside a packet
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= 1'b0;
      acc_len_q <= '0;
      fill_q    <= '0;
      xor_q     <= '0;
    end else begin
      header_q  <= header_d;
      acc_len_q <= acc_len_d;
      fill_q    <= fill_d;
      xor_q     <= xor_d;
    end
  end

  // packet store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  // readout index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      last_idx_q <= '0;
    end else if (cmd_i.emit_start) begin
      idx_q      <= '0;
      last_idx_q <= AddrW'(acc_len_q - LenW'(1));
    end else if (cmd_i.load_out) begin
      idx_q <= idx_q + AddrW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (tx_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q <= rd_data_q;
      out_last_q <= status_o.at_last;
    end
  end

  assign tx_valid_o = out_valid_q;
  assign tx_byte_o  = out_byte_q;
  assign tx_last_o  = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(StoreDepth))
    else $error("fill count beyond store depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || tx_ready_i))
    else $error("output register overwritten");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && status_o.at_last) |=> (out_valid_q && out_last_q))
    else $error("final beat lacks last marker");

  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en || cmd_i.load_out) |-> !wr_en)
    else $error("store written during readout");

endmodule

// ===== src/xor_checksum_packet_deframer.sv =====
// Top level: flag/length/XOR-checksum packet deframer.
// Operation: bytes are taken while the controller is idle; after a good end flag each payload
// beat is read from the store into a read register, then loaded into the output register
// once that is free, so the sink can stall the readout. Reception pauses while a verified
// packet is read out of the store.
// Reset: config returns to length 1 and both flags 0; frame state and output cleared.
`timescale 1ns / 1ps
module xor_checksum_packet_deframer
  import xcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  xcd_rx_if.sink              rx_i,
  xcd_tx_if.source            tx_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  xcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xcd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_byte_i  (rx_i.rx_byte),
    .tx_ready_i (tx_o.ready),
    .tx_valid_o (tx_o.valid),
    .tx_byte_o  (tx_o.payload_byte),
    .tx_last_o  (tx_o.last),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
